// ----- design/mlr_pkg.sv -----
package mlr_pkg;

	localparam int MAX_LIMBS = 32;
	localparam int OP_DEPTH = 2 * MAX_LIMBS + 1;
	localparam int LIMB_W = 64;
	localparam int MOD_AW = $clog2(MAX_LIMBS);
	localparam int OP_AW = $clog2(OP_DEPTH);
	localparam int SIZE_W = 6;
	localparam int IDX_W = 7;

	localparam logic [1:0] OPC_LOAD_MOD = 2'd0;
	localparam logic [1:0] OPC_LOAD_OP = 2'd1;
	localparam logic [1:0] OPC_REDUCE = 2'd2;

	localparam logic CFG_RHO = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

	// operand store access for one cycle
	typedef struct packed {
		logic wr;
		logic clr;
		logic [OP_AW-1:0] addr;
	} opmem_req_t;

endpackage

// ----- design/montgomery_limb_reduction.sv -----
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------------
// command  | cmd_valid/cmd_stall  | opcode, limb_index, limb_value, operand_negative
// result   | res_valid/res_stall  | result_limb, result_index, result_negative, last
// config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A reduce over n modulus limbs is paced by the single 32x32 multiplier (each limb product
// takes a read, a launch, four partial products and the final add) and the one-port
// operand store, plus the carry ripple steps and the emitted limbs.
// Reset clears control and marks the operand store empty; no clearing pass is needed.
// cmd_stall is high for the whole reduce until the last result limb is taken.
module montgomery_limb_reduction (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input logic [1:0] opcode,
	input logic [6:0] limb_index,
	input logic [63:0] limb_value,
	input logic operand_negative,
	output logic res_valid,
	input logic res_stall,
	output logic [63:0] result_limb,
	output logic [5:0] result_index,
	output logic result_negative,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [63:0] cfg_data
);
	import mlr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_MU_RD, S_MU_GO, S_MU_WT, S_MJ_RD, S_MJ_GO, S_MJ_WT,
		S_CR_RD, S_CR_ADD, S_CT_RD, S_CT_CHK, S_CM_RD, S_CM_CHK,
		S_SB_RD, S_SB_OP, S_EM_RD, S_EM_LD, S_EM_HOLD
	} state_t;

	state_t state_q;
	logic [LIMB_W-1:0] rho_q;
	logic [SIZE_W-1:0] size_q, n_q;
	logic [MOD_AW-1:0] i_q;
	logic [SIZE_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [LIMB_W-1:0] mu_q, u_q;
	logic neg_q, ge_q, borrow_q, nz_q;
	logic [LIMB_W-1:0] res_limb_q;
	logic [SIZE_W-1:0] res_idx_q;
	logic res_neg_q, res_last_q, res_valid_q;

	logic [LIMB_W-1:0] mod_mem [MAX_LIMBS];
	logic [LIMB_W-1:0] mod_rd_q;
	logic [MOD_AW-1:0] mod_raddr;

	opmem_req_t op_req;
	logic [LIMB_W-1:0] op_wdata, op_rd;
	logic mac_start, mac_done;
	logic [LIMB_W-1:0] mac_a, mac_b, mac_c1, mac_c2;
	logic [2*LIMB_W-1:0] mac_res;

	logic accept;
	logic [SIZE_W-1:0] n_eff;
	logic [IDX_W-1:0] i_plus_j, n_plus_j, limbs;
	logic last_i, j_is_n;
	logic [LIMB_W:0] carry_sum, diff;
	logic [LIMB_W-1:0] sub_m;

	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	// modulus size clamped to 1..MAX_LIMBS
	always_comb begin
		if (size_q == '0) begin
			n_eff = SIZE_W'(1);
		end else if (size_q > SIZE_W'(MAX_LIMBS)) begin
			n_eff = SIZE_W'(MAX_LIMBS);
		end else begin
			n_eff = size_q;
		end
	end

	// address arithmetic
	assign i_plus_j = IDX_W'(i_q) + IDX_W'(j_q);
	assign n_plus_j = IDX_W'(n_q) + IDX_W'(j_q);
	assign limbs = {n_q, 1'b1};
	assign last_i = i_q == MOD_AW'(n_q - SIZE_W'(1));
	assign j_is_n = j_q == n_q;
	assign carry_sum = {1'b0, op_rd} + {1'b0, u_q};
	assign sub_m = (ge_q && !j_is_n) ? mod_rd_q : '0;
	assign diff = {1'b0, op_rd} - {1'b0, sub_m} - {{LIMB_W{1'b0}}, borrow_q};

	// modulus store, registered read
	always_ff @(posedge clk) begin
		if (accept && opcode == OPC_LOAD_MOD && limb_index < IDX_W'(MAX_LIMBS)) begin
			mod_mem[limb_index[MOD_AW-1:0]] <= limb_value;
		end
		mod_rd_q <= mod_mem[mod_raddr];
	end

	// memory addressing and multiplier launch per state
	always_comb begin
		op_req = '0;
		op_wdata = mac_res[LIMB_W-1:0];
		mod_raddr = '0;
		mac_start = 1'b0;
		mac_a = mu_q;
		mac_b = mod_rd_q;
		mac_c1 = u_q;
		mac_c2 = op_rd;
		unique case (state_q)
			S_IDLE: begin
				op_wdata = limb_value;
				op_req.addr = limb_index;
				op_req.wr = accept && opcode == OPC_LOAD_OP
					&& limb_index < IDX_W'(OP_DEPTH);
			end
			S_MU_RD: op_req.addr = IDX_W'(i_q);
			S_MU_GO: begin
				mac_start = 1'b1;
				mac_a = op_rd;
				mac_b = rho_q;
				mac_c1 = '0;
				mac_c2 = '0;
			end
			S_MJ_RD: begin
				op_req.addr = i_plus_j;
				mod_raddr = j_q[MOD_AW-1:0];
			end
			S_MJ_GO: mac_start = 1'b1;
			S_MJ_WT: begin
				op_req.addr = i_plus_j;
				op_req.wr = mac_done;
			end
			S_CR_RD: op_req.addr = k_q;
			S_CR_ADD: begin
				op_req.addr = k_q;
				op_req.wr = 1'b1;
				op_wdata = carry_sum[LIMB_W-1:0];
			end
			S_CT_RD: op_req.addr = {n_q, 1'b0};
			S_CM_RD: begin
				op_req.addr = n_plus_j - IDX_W'(1);
				mod_raddr = MOD_AW'(j_q - SIZE_W'(1));
			end
			S_SB_RD: begin
				op_req.addr = n_plus_j;
				mod_raddr = j_q[MOD_AW-1:0];
			end
			S_SB_OP: begin
				op_req.addr = n_plus_j;
				op_req.wr = 1'b1;
				op_wdata = diff[LIMB_W-1:0];
			end
			S_EM_RD: op_req.addr = n_plus_j;
			S_EM_HOLD: op_req.clr = !res_stall && res_last_q;
			default: ;
		endcase
	end

	mlr_opmem u_opmem (
		.clk(clk),
		.arst_n(arst_n),
		.req(op_req),
		.wdata(op_wdata),
		.rdata(op_rd)
	);

	mlr_mulacc u_mulacc (
		.clk(clk),
		.arst_n(arst_n),
		.start(mac_start),
		.a(mac_a),
		.b(mac_b),
		.c1(mac_c1),
		.c2(mac_c2),
		.done(mac_done),
		.result(mac_res)
	);

	// reduction sequencer with result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rho_q <= '0;
			size_q <= SIZE_W'(1);
			n_q <= SIZE_W'(1);
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			mu_q <= '0;
			u_q <= '0;
			neg_q <= 1'b0;
			ge_q <= 1'b0;
			borrow_q <= 1'b0;
			nz_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_limb_q <= '0;
			res_idx_q <= '0;
			res_neg_q <= 1'b0;
			res_last_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RHO) begin
					rho_q <= cfg_data;
				end else begin
					size_q <= cfg_data[SIZE_W-1:0];
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == OPC_REDUCE) begin
						n_q <= n_eff;
						neg_q <= operand_negative;
						i_q <= '0;
						state_q <= S_MU_RD;
					end
				end
				S_MU_RD: state_q <= S_MU_GO;
				S_MU_GO: state_q <= S_MU_WT;
				S_MU_WT: begin
					if (mac_done) begin
						mu_q <= mac_res[LIMB_W-1:0];
						u_q <= '0;
						j_q <= '0;
						state_q <= S_MJ_RD;
					end
				end
				S_MJ_RD: state_q <= S_MJ_GO;
				S_MJ_GO: state_q <= S_MJ_WT;
				S_MJ_WT: begin
					if (mac_done) begin
						u_q <= mac_res[2*LIMB_W-1:LIMB_W];
						if (j_q == n_q - SIZE_W'(1)) begin
							k_q <= IDX_W'(i_q) + IDX_W'(n_q);
							state_q <= S_CR_RD;
						end else begin
							j_q <= j_q + SIZE_W'(1);
							state_q <= S_MJ_RD;
						end
					end
				end
				S_CR_RD: begin
					if (u_q == '0 || k_q >= limbs) begin
						if (last_i) begin
							state_q <= S_CT_RD;
						end else begin
							i_q <= i_q + MOD_AW'(1);
							state_q <= S_MU_RD;
						end
					end else begin
						state_q <= S_CR_ADD;
					end
				end
				S_CR_ADD: begin
					u_q <= {{(LIMB_W-1){1'b0}}, carry_sum[LIMB_W]};
					k_q <= k_q + IDX_W'(1);
					state_q <= S_CR_RD;
				end
				S_CT_RD: state_q <= S_CT_CHK;
				S_CT_CHK: begin
					borrow_q <= 1'b0;
					nz_q <= 1'b0;
					if (op_rd != '0) begin
						ge_q <= 1'b1;
						j_q <= '0;
						state_q <= S_SB_RD;
					end else begin
						j_q <= n_q;
						state_q <= S_CM_RD;
					end
				end
				S_CM_RD: state_q <= S_CM_CHK;
				S_CM_CHK: begin
					if (op_rd != mod_rd_q) begin
						ge_q <= op_rd > mod_rd_q;
						j_q <= '0;
						state_q <= S_SB_RD;
					end else if (j_q == SIZE_W'(1)) begin
						ge_q <= 1'b1;
						j_q <= '0;
						state_q <= S_SB_RD;
					end else begin
						j_q <= j_q - SIZE_W'(1);
						state_q <= S_CM_RD;
					end
				end
				S_SB_RD: state_q <= S_SB_OP;
				S_SB_OP: begin
					borrow_q <= diff[LIMB_W];
					nz_q <= nz_q || diff[LIMB_W-1:0] != '0;
					if (j_is_n) begin
						j_q <= '0;
						state_q <= S_EM_RD;
					end else begin
						j_q <= j_q + SIZE_W'(1);
						state_q <= S_SB_RD;
					end
				end
				S_EM_RD: state_q <= S_EM_LD;
				S_EM_LD: begin
					res_limb_q <= op_rd;
					res_idx_q <= j_q;
					res_neg_q <= neg_q && nz_q;
					res_last_q <= j_is_n;
					res_valid_q <= 1'b1;
					state_q <= S_EM_HOLD;
				end
				S_EM_HOLD: begin
					if (!res_stall) begin
						res_valid_q <= 1'b0;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							j_q <= j_q + SIZE_W'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign result_limb = res_limb_q;
	assign result_index = res_idx_q;
	assign result_negative = res_neg_q;
	assign last = res_last_q;

endmodule

// ----- design/mlr_opmem.sv -----
module mlr_opmem (
	input logic clk,
	input logic arst_n,
	input mlr_pkg::opmem_req_t req,
	input logic [mlr_pkg::LIMB_W-1:0] wdata,
	output logic [mlr_pkg::LIMB_W-1:0] rdata
);
	import mlr_pkg::*;

	logic [LIMB_W-1:0] mem [OP_DEPTH];
	logic [OP_DEPTH-1:0] valid_q;
	logic [LIMB_W-1:0] rdata_q;
	logic rvalid_q;

	// data array, registered read
	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.addr] <= wdata;
		end
		rdata_q <= mem[req.addr];
	end

	// per-entry valid bits, an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= valid_q[req.addr];
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr) begin
				valid_q[req.addr] <= 1'b1;
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ----- design/mlr_mulacc.sv -----
module mlr_mulacc (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [mlr_pkg::LIMB_W-1:0] a,
	input logic [mlr_pkg::LIMB_W-1:0] b,
	input logic [mlr_pkg::LIMB_W-1:0] c1,
	input logic [mlr_pkg::LIMB_W-1:0] c2,
	output logic done,
	output logic [2*mlr_pkg::LIMB_W-1:0] result
);
	import mlr_pkg::*;

	logic [LIMB_W-1:0] a_q, b_q;
	logic [2*LIMB_W-1:0] acc_q;
	logic [LIMB_W-1:0] prod_s1;
	logic [1:0] tag_s1;
	logic [2:0] cnt_q;
	logic busy_q, done_q;
	logic [31:0] a_part, b_part;
	logic [2*LIMB_W-1:0] addend;

	// pick the 32-bit halves for this partial product
	assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	// align the previous partial product
	always_comb begin
		case (tag_s1)
			2'd0: addend = {64'b0, prod_s1};
			2'd3: addend = {prod_s1, 64'b0};
			default: addend = {32'b0, prod_s1, 32'b0};
		endcase
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		prod_s1 <= a_part * b_part;
		tag_s1 <= cnt_q[1:0];
	end

	// four partial products, one per cycle, summed into the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				acc_q <= {63'b0, {1'b0, c1} + {1'b0, c2}};
			end else if (busy_q) begin
				if (cnt_q != 3'd0) begin
					acc_q <= acc_q + addend;
				end
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	assign done = done_q;
	assign result = acc_q;

endmodule
